>>> rtl/skst_pkg.sv
`default_nettype none

package skst_pkg;

    localparam int KEY_W    = 64;
    localparam int OUT_W    = 9;
    localparam int TREE_FAN = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } skst_cmd_t;

    function automatic int tree_size(input int n, input int lvl);
        int s;
        s = n;
        for (int i = 0; i < lvl; i++) begin
            s = (s + TREE_FAN - 1) / TREE_FAN;
        end
        return s;
    endfunction

    function automatic int tree_levels(input int n);
        int s;
        int l;
        s = n;
        l = 0;
        for (int i = 0; i < 16; i++) begin
            if (s > 1) begin
                s = (s + TREE_FAN - 1) / TREE_FAN;
                l = l + 1;
            end
        end
        return l;
    endfunction

    function automatic int tree_off(input int n, input int lvl);
        int o;
        o = 0;
        for (int i = 1; i < lvl; i++) begin
            o = o + tree_size(n, i);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/skst_cell.sv
`default_nettype none

module skst_cell import skst_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int IDX   = 0
) (
    input  wire logic                           aclk,
    input  wire skst_cmd_t                      cmd,
    input  wire logic [KEY_W-1:0]               probe_key,
    input  wire logic [$clog2(DEPTH)-1:0]       pos,
    input  wire logic [$clog2(DEPTH+1)-1:0]     occ,
    input  wire logic [KEY_W-1:0]               prev_key,
    input  wire logic [KEY_W-1:0]               next_key,
    output logic      [KEY_W-1:0]               key_out,
    output logic                                lt,
    output logic                                eq
);

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] key_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             live;

    assign live    = PW'(IDX) < occ;
    assign key_out = key_reg;
    assign lt      = lt_reg;
    assign eq      = eq_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cmp_en) begin
            lt_reg <= live && ($signed(key_reg) < $signed(probe_key));
            eq_reg <= live && (key_reg == probe_key);
        end
        if (cmd.ins_en) begin
            if (IW'(IDX) > pos) begin
                key_reg <= prev_key;
            end else if (IW'(IDX) == pos) begin
                key_reg <= probe_key;
            end
        end else if (cmd.rem_en) begin
            if (IW'(IDX) >= pos) begin
                key_reg <= next_key;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/skst_or_tree.sv
`default_nettype none

module skst_or_tree import skst_pkg::*; #(
    parameter int N = 256,
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] leaf [N],
    output logic      [W-1:0] root
);

    localparam int L = tree_levels(N);
    localparam int T = tree_off(N, L + 1);

    logic [W-1:0] node_reg [T];

    for (genvar l = 1; l <= L; l++) begin : g_lvl
        localparam int SZ   = tree_size(N, l);
        localparam int OFF  = tree_off(N, l);
        localparam int PSZ  = tree_size(N, l - 1);
        localparam int POFF = tree_off(N, l - 1);
        for (genvar j = 0; j < SZ; j++) begin : g_node
            logic [W-1:0] acc;
            if (l == 1) begin : g_first
                always_comb begin
                    acc = '0;
                    for (int k = 0; k < TREE_FAN; k++) begin
                        if (j * TREE_FAN + k < PSZ) begin
                            acc = acc | leaf[j * TREE_FAN + k];
                        end
                    end
                end
            end else begin : g_upper
                always_comb begin
                    acc = '0;
                    for (int k = 0; k < TREE_FAN; k++) begin
                        if (j * TREE_FAN + k < PSZ) begin
                            acc = acc | node_reg[POFF + j * TREE_FAN + k];
                        end
                    end
                end
            end
            always_ff @(posedge aclk) begin
                node_reg[OFF + j] <= acc;
            end
        end
    end

    assign root = node_reg[T-1];

endmodule

`default_nettype wire

>>> rtl/sorted_key_set_table.sv
// Sorted set of distinct signed 64-bit keys, held in a row of compare cells.
// Input channel (s_valid/s_ready): operation, key, rank. Operations are
// insert, remove, find and read-at-rank. Output channel (m_valid/m_ready):
// status, present, position, read_key and the count after the operation.
// Every input beat yields exactly one output beat, in order.
// One item at a time: a beat is accepted, every cell compares its key with
// the probe key into its registered lt/eq flags, a registered OR tree of
// fan-in 16 with L levels (L = ceil(log16 DEPTH), 2 at DEPTH 256) collects
// the match, insertion point and read data, and a final update state shifts
// the cells and loads the result. A new beat is taken only once that is done.
// The output register holds a result while m_ready is low; the next beat can
// be accepted meanwhile, and its update waits until the held result is taken.
// Reset (aresetn low, synchronous) empties the set and drops any beat in
// flight; the key storage itself is not cleared.
`default_nettype none

module sorted_key_set_table import skst_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_operation,
    input  wire logic signed [KEY_W-1:0]  s_key,
    input  wire logic [7:0]               s_rank,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_present,
    output logic [OUT_W-1:0]              m_position,
    output logic signed [KEY_W-1:0]       m_read_key,
    output logic [OUT_W-1:0]              m_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int TW = 1 + IW + KEY_W;
    localparam int L  = tree_levels(DEPTH);
    localparam int CW = (L > 1) ? $clog2(L) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_UPD  = 4'b1000
    } skst_state_t;

    skst_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] occ_reg, occ_next;

    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [7:0]       rank_reg;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic             m_present_reg;
    logic [OUT_W-1:0] m_position_reg;
    logic [KEY_W-1:0] m_read_key_reg;
    logic [OUT_W-1:0] m_count_reg;

    logic [KEY_W-1:0] cell_key [DEPTH];
    logic             cell_lt  [DEPTH];
    logic             cell_eq  [DEPTH];
    logic [TW-1:0]    leaf     [DEPTH];
    logic [TW-1:0]    root;

    skst_cmd_t        cmd;
    logic             out_go;
    logic             hit;
    logic             full;
    logic             in_range;
    logic [PW-1:0]    ins_pos;
    logic [1:0]       status_n;
    logic             present_n;
    logic [PW-1:0]    pos_n;
    logic [KEY_W-1:0] rkey_n;
    logic             ins_ok;
    logic             rem_ok;

    assign s_ready    = (state_reg == ST_IDLE);
    assign out_go     = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_present  = m_present_reg;
    assign m_position = m_position_reg;
    assign m_read_key = m_read_key_reg;
    assign m_count    = m_count_reg;

    assign cmd.cmp_en = (state_reg == ST_CMP);
    assign cmd.ins_en = (state_reg == ST_UPD) && out_go && ins_ok;
    assign cmd.rem_en = (state_reg == ST_UPD) && out_go && rem_ok;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] prev_k;
        logic [KEY_W-1:0] next_k;
        logic             first;
        logic             sel;

        if (i == 0) begin : g_head
            assign prev_k = key_reg;
            assign first  = !cell_lt[i];
        end else begin : g_body
            assign prev_k = cell_key[i-1];
            assign first  = !cell_lt[i] && cell_lt[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign next_k = cell_key[i];
        end else begin : g_mid
            assign next_k = cell_key[i+1];
        end

        assign sel     = (32'(rank_reg) == i) && (PW'(i) < occ_reg);
        assign leaf[i] = {cell_eq[i],
                          first ? IW'(i) : {IW{1'b0}},
                          sel ? cell_key[i] : {KEY_W{1'b0}}};

        skst_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .probe_key (key_reg),
            .pos       (IW'(ins_pos)),
            .occ       (occ_reg),
            .prev_key  (prev_k),
            .next_key  (next_k),
            .key_out   (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    skst_or_tree #(
        .N (DEPTH),
        .W (TW)
    ) u_tree (
        .aclk (aclk),
        .leaf (leaf),
        .root (root)
    );

    always_comb begin
        hit       = root[TW-1];
        ins_pos   = cell_lt[DEPTH-1] ? PW'(DEPTH) : PW'(root[KEY_W +: IW]);
        full      = (occ_reg == PW'(DEPTH));
        in_range  = 32'(rank_reg) < 32'(occ_reg);
        status_n  = STATUS_DONE;
        present_n = hit;
        pos_n     = ins_pos;
        rkey_n    = '0;
        occ_next  = occ_reg;
        ins_ok    = 1'b0;
        rem_ok    = 1'b0;
        unique case (op_reg)
            OP_INSERT: begin
                if (hit) begin
                    status_n = STATUS_NO_CHANGE;
                end else if (full) begin
                    status_n = STATUS_ERROR;
                end else begin
                    ins_ok   = 1'b1;
                    occ_next = occ_reg + PW'(1);
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    status_n = STATUS_NO_CHANGE;
                end else begin
                    rem_ok   = 1'b1;
                    occ_next = occ_reg - PW'(1);
                end
            end
            OP_FIND: begin
            end
            OP_READ: begin
                present_n = 1'b0;
                pos_n     = '0;
                if (in_range) begin
                    rkey_n = root[KEY_W-1:0];
                end else begin
                    status_n = STATUS_ERROR;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_SUM;
                cnt_next   = '0;
            end
            ST_SUM: begin
                if (cnt_reg == CW'(L - 1)) begin
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_UPD: begin
                if (out_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_UPD) && out_go) begin
                occ_reg     <= occ_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            key_reg  <= s_key;
            rank_reg <= s_rank;
        end
        if ((state_reg == ST_UPD) && out_go) begin
            m_status_reg   <= status_n;
            m_present_reg  <= present_n;
            m_position_reg <= OUT_W'(pos_n);
            m_read_key_reg <= rkey_n;
            m_count_reg    <= OUT_W'(occ_next);
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_sorted_key_set_table.sv
`default_nettype none

module tb_sorted_key_set_table;
    import skst_pkg::*;

    localparam int DEPTH = 256;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic [7:0]              rank;
    } set_req_t;

    typedef struct {
        logic [1:0]              status;
        logic                    present;
        logic [OUT_W-1:0]        position;
        logic signed [KEY_W-1:0] read_key;
        logic [OUT_W-1:0]        count;
    } set_resp_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_operation = OP_FIND;
    logic signed [KEY_W-1:0] s_key = '0;
    logic [7:0]              s_rank = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic                    m_present;
    logic [OUT_W-1:0]        m_position;
    logic signed [KEY_W-1:0] m_read_key;
    logic [OUT_W-1:0]        m_count;

    set_req_t                pending_ops[$];
    set_resp_t               expected_results[$];
    logic signed [KEY_W-1:0] table_keys [DEPTH];
    int                      table_count = 0;
    logic signed [KEY_W-1:0] held_keys[$];
    int                      mismatch_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;

    sorted_key_set_table #(.DEPTH(DEPTH)) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_key      (s_key),
        .s_rank     (s_rank),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_present  (m_present),
        .m_position (m_position),
        .m_read_key (m_read_key),
        .m_count    (m_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic set_resp_t apply_set_op(set_req_t req);
        set_resp_t r;
        int        pos;
        bit        hit;
        r.status   = STATUS_DONE;
        r.present  = 1'b0;
        r.position = '0;
        r.read_key = '0;
        pos = 0;
        while (pos < table_count && table_keys[pos] < req.key) pos++;
        hit = (pos < table_count) && (table_keys[pos] == req.key);
        if (req.op == OP_READ) begin
            if (int'(req.rank) < table_count) begin
                r.read_key = table_keys[req.rank];
            end else begin
                r.status = STATUS_ERROR;
            end
        end else begin
            r.present  = hit;
            r.position = OUT_W'(pos);
            if (req.op == OP_INSERT) begin
                if (hit) begin
                    r.status = STATUS_NO_CHANGE;
                end else if (table_count >= DEPTH) begin
                    r.status = STATUS_ERROR;
                end else begin
                    for (int i = table_count; i > pos; i--) table_keys[i] = table_keys[i-1];
                    table_keys[pos] = req.key;
                    table_count++;
                end
            end else if (req.op == OP_REMOVE) begin
                if (!hit) begin
                    r.status = STATUS_NO_CHANGE;
                end else begin
                    for (int i = pos; i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
                    table_count--;
                end
            end
        end
        r.count = OUT_W'(table_count);
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        if (mismatch_count < 40) begin
            $display("mismatch in %0s at %0t: got %h, want %h", what, $realtime, got, want);
        end
        mismatch_count++;
    endtask

    // driver: hold the beat until accepted, then predict and advance
    always @(posedge aclk) begin
        set_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            s_valid <= 1'b1;
        end else begin
            if (s_valid) begin
                expected_results.push_back(apply_set_op('{s_operation, s_key, s_rank}));
            end
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_ops.pop_front();
                s_valid     <= 1'b1;
                s_operation <= nxt.op;
                s_key       <= nxt.key;
                s_rank      <= nxt.rank;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        set_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected beat", KEY_W'(m_status), '0);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    note_mismatch("status", KEY_W'(m_status), KEY_W'(want.status));
                if (m_present !== want.present)
                    note_mismatch("present", KEY_W'(m_present), KEY_W'(want.present));
                if (m_position !== want.position)
                    note_mismatch("position", KEY_W'(m_position), KEY_W'(want.position));
                if (m_read_key !== want.read_key)
                    note_mismatch("read_key", m_read_key, want.read_key);
                if (m_count !== want.count)
                    note_mismatch("count", KEY_W'(m_count), KEY_W'(want.count));
            end
        end
    end

    task automatic queue_op(logic [1:0] op, logic signed [KEY_W-1:0] key, logic [7:0] rank);
        pending_ops.push_back('{op, key, rank});
    endtask

    task automatic drain_all();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(bit prefer_held);
        logic signed [KEY_W-1:0] k;
        int                      sel;
        sel = $urandom_range(0, 99);
        if (prefer_held && held_keys.size() != 0 && sel < 70) begin
            k = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end else if (sel < 80) begin
            k = {$urandom, $urandom};
        end else if (sel < 94) begin
            k = KEY_W'($urandom_range(0, 16));
            k = k - 8;
        end else begin
            k = ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
        end
        return k;
    endfunction

    task automatic queue_random(int n, int ins_pct, int rem_pct, int find_pct);
        int                      sel;
        int                      rank;
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        held_keys.delete();
        for (int i = 0; i < table_count; i++) held_keys.push_back(table_keys[i]);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < ins_pct) op = OP_INSERT;
            else if (sel < ins_pct + rem_pct) op = OP_REMOVE;
            else if (sel < ins_pct + rem_pct + find_pct) op = OP_FIND;
            else op = OP_READ;
            key = pick_key(op != OP_INSERT || $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 1) != 0) rank = $urandom_range(0, 255);
            else rank = $urandom_range(0, (table_count < 255) ? table_count : 255);
            queue_op(op, key, 8'(rank));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        queue_op(OP_READ,   '0,      8'd0);
        queue_op(OP_FIND,   '0,      8'd0);
        queue_op(OP_REMOVE, 64'sd5,  8'd0);
        queue_op(OP_INSERT, '0,      8'd0);
        queue_op(OP_INSERT, KEY_MIN, 8'd0);
        queue_op(OP_INSERT, KEY_MAX, 8'd0);
        queue_op(OP_INSERT, -64'sd1, 8'd0);
        queue_op(OP_INSERT, 64'sd1,  8'd0);
        queue_op(OP_INSERT, KEY_MAX, 8'd0);
        queue_op(OP_FIND,   KEY_MIN, 8'd0);
        queue_op(OP_FIND,   KEY_MAX, 8'd0);
        queue_op(OP_FIND,   64'sd2,  8'd0);
        queue_op(OP_READ,   '0,      8'd0);
        queue_op(OP_READ,   '0,      8'd4);
        queue_op(OP_READ,   '0,      8'd5);
        queue_op(OP_READ,   '1,      8'd255);
        queue_op(OP_REMOVE, '0,      8'd0);
        queue_op(OP_REMOVE, KEY_MIN, 8'd0);
        queue_op(OP_REMOVE, KEY_MAX, 8'd0);
        queue_op(OP_FIND,   -64'sd1, 8'd0);
        queue_op(OP_INSERT, KEY_MIN + 64'sd1, 8'd128);
        queue_op(OP_INSERT, KEY_MAX - 64'sd1, 8'd127);
        queue_op(OP_READ,   '0,      8'd3);
        drain_all();

        send_idle_pct  = 55;
        recv_stall_pct = 0;
        queue_random(80, 40, 20, 20);
        drain_all();

        send_idle_pct  = 19;
        recv_stall_pct = 19;
        queue_random(DEPTH - table_count + 100, 96, 0, 2);
        drain_all();

        send_idle_pct  = 0;
        recv_stall_pct = 55;
        queue_random(80, 15, 55, 15);
        drain_all();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(30, 30, 30, 20);
        drain_all();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
